// ===== hw/rtl/md5_entropy_pool_rng_defines.svh =====
// assertion macros for the entropy pool generator checker
// no dependencies
`ifndef MD5_ENTROPY_POOL_RNG_DEFINES_SVH
`define MD5_ENTROPY_POOL_RNG_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MEP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define MEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/mep_pkg.sv =====
// shared constants and round tables for the md5 entropy pool generator
// no dependencies
`timescale 1ns / 1ps
package mep_pkg;
   localparam int unsigned PoolBytes = 64;
   localparam int unsigned PosWidth = 6;
   localparam int unsigned FeedbackBytes = 12;
   localparam logic [31:0] Iv0 = 32'h67452301;
   localparam logic [31:0] Iv1 = 32'hefcdab89;
   localparam logic [31:0] Iv2 = 32'h98badcfe;
   localparam logic [31:0] Iv3 = 32'h10325476;
   localparam logic ReqAdd = 1'b0;
   localparam logic ReqGenerate = 1'b1;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
         6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
         6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_s(input logic [3:0] j);
      logic [4:0] s;
      unique case (j)
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
   endfunction
endpackage

// ===== hw/rtl/md5_entropy_pool_rng.sv =====
// channel   ports                                     role
// req       req_valid req_ready req_req_type ...      add byte or generate request
// rsp       rsp_valid rsp_ready rsp_random_word       one word per generate item
// add item: accept, pool byte read, pool byte write
// generate item: accept, 3 time bytes read and written, 64 byte loads, 64 rounds, 1 final add,
//   12 feedback bytes read and written, 1 output; serial, with one memory port and one round adder
// reset clears the pool by a sweep of all 64 bytes, req_ready low meanwhile
// a result waiting for rsp_ready holds the next generate item in its output state
// depends on mep_pkg
`timescale 1ns / 1ps
module md5_entropy_pool_rng import mep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_req_type,
   input  logic [7:0]  req_entropy_byte,
   input  logic [19:0] req_time_usec,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_random_word
);
   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001, ST_IDLE = 8'b0000_0010, ST_MIXRD = 8'b0000_0100,
      ST_MIXWR = 8'b0000_1000, ST_LOAD = 8'b0001_0000, ST_ROUND = 8'b0010_0000,
      ST_FINAL = 8'b0100_0000, ST_OUT = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  pool_mem [PoolBytes];
   logic [7:0]  rd_ff;
   logic [PosWidth-1:0] pos_ff, pos_in, clr_ff, clr_in;
   logic        gen_ff, gen_in;
   logic [3:0]  mix_cnt_ff, mix_cnt_in;
   logic [7:0]  mix_val;
   logic [19:0] time_ff, time_in;
   logic [7:0]  byte_ff, byte_in;
   logic [31:0] msg_ff [16];
   logic [5:0]  ld_ff, ld_in;
   logic        ld_v_ff;
   logic [5:0]  ld_addr_ff;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] word_ff, word_in;
   logic        mem_we;
   logic [5:0]  mem_addr;
   logic [7:0]  mem_wd;
   logic [1:0]  r;
   logic [31:0] f, sum, rot;
   logic [3:0]  g;
   logic [4:0]  sh;
   logic [31:0] st_word;

   always_comb begin
      st_word = a_ff;
      unique case (mix_cnt_ff)
         4'd0: mix_val = gen_ff ? time_ff[7:0] : byte_ff;
         4'd1: mix_val = time_ff[15:8];
         4'd2: mix_val = {4'd0, time_ff[19:16]};
         default: begin
            unique case (mix_cnt_ff[3:2] - 2'd1)
               2'd0: st_word = a_ff;
               2'd1: st_word = b_ff;
               default: st_word = c_ff;
            endcase
            mix_val = st_word[8*mix_cnt_ff[1:0] +: 8];
         end
      endcase
   end

   always_comb begin
      r = rnd_ff[5:4];
      unique case (r)
         2'd0: begin f = (b_ff & c_ff) | (~b_ff & d_ff); g = rnd_ff[3:0]; end
         2'd1: begin
            f = (d_ff & b_ff) | (~d_ff & c_ff);
            g = 4'(5 * rnd_ff[3:0] + 1);
         end
         2'd2: begin f = b_ff ^ c_ff ^ d_ff; g = 4'(3 * rnd_ff[3:0] + 5); end
         default: begin f = c_ff ^ (b_ff | ~d_ff); g = 4'(7 * rnd_ff[3:0]); end
      endcase
      sh  = md5_s({r, rnd_ff[1:0]});
      sum = a_ff + f + md5_k(rnd_ff) + msg_ff[g];
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   end

   always_comb begin
      state_in = state_ff; pos_in = pos_ff; clr_in = clr_ff; gen_in = gen_ff;
      mix_cnt_in = mix_cnt_ff; time_in = time_ff; byte_in = byte_ff;
      ld_in = ld_ff; rnd_in = rnd_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready; word_in = word_ff;
      mem_we = 1'b0; mem_addr = pos_ff; mem_wd = rd_ff ^ mix_val;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1; mem_addr = clr_ff; mem_wd = 8'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == 6'(PoolBytes - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               gen_in = req_req_type == ReqGenerate; byte_in = req_entropy_byte;
               time_in = req_time_usec; mix_cnt_in = 4'd0; state_in = ST_MIXRD;
            end
         end
         ST_MIXRD: state_in = ST_MIXWR;
         ST_MIXWR: begin
            mem_we = 1'b1; pos_in = pos_ff + 1'b1; mix_cnt_in = mix_cnt_ff + 1'b1;
            if (!gen_ff) state_in = ST_IDLE;
            else if (mix_cnt_ff == 4'd2) begin
               state_in = ST_LOAD; ld_in = 6'd0;
            end else if (mix_cnt_ff == 4'(3 + FeedbackBytes)) state_in = ST_OUT;
            else state_in = ST_MIXRD;
         end
         ST_LOAD: begin
            mem_addr = ld_ff; ld_in = ld_ff + 1'b1;
            if (ld_ff == 6'(PoolBytes - 1)) begin
               state_in = ST_ROUND; rnd_in = 6'd0;
               a_in = Iv0; b_in = Iv1; c_in = Iv2; d_in = Iv3;
            end
         end
         ST_ROUND: begin
            a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_ff + rot;
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == 6'd63) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            a_in = a_ff + Iv0; b_in = b_ff + Iv1; c_in = c_ff + Iv2; d_in = d_ff + Iv3;
            mix_cnt_in = 4'd4; state_in = ST_MIXRD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1; word_in = d_ff; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_random_word = word_ff;

   always_ff @(posedge clock) begin
      if (mem_we) pool_mem[mem_addr] <= mem_wd;
      rd_ff <= pool_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      ld_v_ff <= state_ff == ST_LOAD;
      ld_addr_ff <= ld_ff;
      if (ld_v_ff) msg_ff[ld_addr_ff[5:2]][8*ld_addr_ff[1:0] +: 8] <= rd_ff;
      gen_ff <= gen_in; mix_cnt_ff <= mix_cnt_in; time_ff <= time_in;
      byte_ff <= byte_in; ld_ff <= ld_in; rnd_ff <= rnd_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; pos_ff <= '0; clr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in; clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== hw/rtl/mep_checker.sv =====
// port-level checker for md5_entropy_pool_rng, bound into every md5_entropy_pool_rng instance
// depends on md5_entropy_pool_rng_defines.svh
`timescale 1ns / 1ps
`include "md5_entropy_pool_rng_defines.svh"
module mep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_req_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_random_word
);
   `MEP_ASSERT_NEXT(a_add_no_rsp, clock, reset, req_valid && req_ready && !req_req_type && !rsp_valid, !rsp_valid, "add item gave a result")
   `MEP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")
   `MEP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_random_word), "result dropped")
   `MEP_ASSERT_IMPL(a_rsp_idle, clock, reset, $rose(rsp_valid), req_ready, "result while block busy")
endmodule

bind md5_entropy_pool_rng mep_checker u_mep_checker (.*);

// ===== test/md5_entropy_pool_rng_test.sv =====
// self-checking testbench for md5_entropy_pool_rng: directed table then random add/generate items
// predicts each random word with its own pool and md5 model; depends on mep_pkg and the rtl
`timescale 1ns / 1ps
module md5_entropy_pool_rng_test;
   import mep_pkg::*;

   localparam int unsigned IdleLimit = 20000;
   localparam int unsigned RandomItems = 830;

   typedef struct packed {
      logic        kind;
      logic [7:0]  entropy;
      logic [19:0] usec;
      logic        has_word;
      logic [31:0] word;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_req_type;
   logic [7:0]  req_entropy_byte;
   logic [19:0] req_time_usec;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_random_word;

   logic [7:0]  pool [PoolBytes];
   logic [5:0]  pos;
   logic [31:0] words_due [$];
   logic [31:0] fixed_words [$];
   logic        fixed_flags [$];
   int unsigned mismatch_count;
   int unsigned idle_cycles;
   int unsigned words_seen;
   int unsigned items_sent;
   int unsigned generates_sent;
   bit          hold_rsp;

   md5_entropy_pool_rng DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_req_type(req_req_type), .req_entropy_byte(req_entropy_byte),
      .req_time_usec(req_time_usec),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_random_word(rsp_random_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] round_const(input int i);
      logic [31:0] k;
      k = 32'(longint'($floor($pow(2.0, 32.0) * (($sin(i + 1.0) < 0.0) ?
            -$sin(i + 1.0) : $sin(i + 1.0)))));
      return k;
   endfunction

   function automatic logic [4:0] round_shift(input int r, input int j);
      logic [4:0] s;
      case (r)
         0: s = (j == 0) ? 5'd7 : (j == 1) ? 5'd12 : (j == 2) ? 5'd17 : 5'd22;
         1: s = (j == 0) ? 5'd5 : (j == 1) ? 5'd9 : (j == 2) ? 5'd14 : 5'd20;
         2: s = (j == 0) ? 5'd4 : (j == 1) ? 5'd11 : (j == 2) ? 5'd16 : 5'd23;
         default: s = (j == 0) ? 5'd6 : (j == 1) ? 5'd10 : (j == 2) ? 5'd15 : 5'd21;
      endcase
      return s;
   endfunction

   task automatic fold_byte(input logic [7:0] v);
      pool[pos] ^= v;
      pos = pos + 6'd1;
   endtask

   // apply one item to the pool; returns 1 with the word on generate
   task automatic predict_item(input logic kind, input logic [7:0] entropy,
                               input logic [19:0] usec, output bit made,
                               output logic [31:0] word);
      logic [31:0] blk [16];
      logic [31:0] st [4];
      logic [31:0] a, b, c, d, f, t, sum;
      int g, r;
      made = 1'b0;
      word = '0;
      if (kind == ReqAdd) begin
         fold_byte(entropy);
         return;
      end
      fold_byte(usec[7:0]);
      fold_byte(usec[15:8]);
      fold_byte({4'h0, usec[19:16]});
      for (int i = 0; i < 16; i++)
         blk[i] = {pool[4*i+3], pool[4*i+2], pool[4*i+1], pool[4*i]};
      st[0] = Iv0; st[1] = Iv1; st[2] = Iv2; st[3] = Iv3;
      a = st[0]; b = st[1]; c = st[2]; d = st[3];
      for (int i = 0; i < 64; i++) begin
         r = i / 16;
         case (r)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
         endcase
         sum = a + f + round_const(i) + blk[g];
         t = d; d = c; c = b;
         b = b + ((sum << round_shift(r, i % 4)) | (sum >> (32 - round_shift(r, i % 4))));
         a = t;
      end
      st[0] += a; st[1] += b; st[2] += c; st[3] += d;
      for (int i = 0; i < FeedbackBytes; i++)
         fold_byte(st[i/4][8*(i%4) +: 8]);
      made = 1'b1;
      word = st[3];
   endtask

   // offer one item and wait until it is taken
   task automatic send_item(input logic kind, input logic [7:0] entropy,
                            input logic [19:0] usec);
      bit made;
      logic [31:0] word;
      req_valid <= 1'b1;
      req_req_type <= kind;
      req_entropy_byte <= entropy;
      req_time_usec <= usec;
      do @(posedge clock); while (!req_ready);
      predict_item(kind, entropy, usec, made, word);
      if (made) begin
         words_due.push_back(word);
         generates_sent++;
      end
      items_sent++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
   endtask

   // receiver: stalls on a pattern, long hold-off when asked
   initial begin
      int unsigned phase;
      phase = 0;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         phase++;
         if (hold_rsp) rsp_ready <= 1'b0;
         else if (phase % 512 < 128) rsp_ready <= 1'b1;
         else rsp_ready <= ((phase % 7) != 3) && ($urandom_range(0, 3) != 0);
      end
   end

   // result check
   always @(posedge clock) begin
      logic        fixed_flag;
      logic [31:0] fixed_word;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (words_due.size() == 0) begin
            $error("random_word: no item expected, actual %h", rsp_random_word);
            mismatch_count++;
         end else begin
            if (fixed_flags.size() != 0) begin
               fixed_flag = fixed_flags.pop_front();
               fixed_word = fixed_words.pop_front();
               if (fixed_flag && fixed_word !== rsp_random_word) begin
                  $error("random_word: table value expected %h, actual %h",
                         fixed_word, rsp_random_word);
                  mismatch_count++;
               end
            end
            if (words_due[0] !== rsp_random_word) begin
               $error("random_word: expected %h, actual %h", words_due[0], rsp_random_word);
               mismatch_count++;
            end
            void'(words_due.pop_front());
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   stim_row_type table_rows [13] = '{
      // generate straight after reset: pool holds only zero time bytes
      '{ReqGenerate, 8'h00, 20'h00000, 1'b0, 32'h0},
      '{ReqAdd, 8'h00, 20'hfffff, 1'b0, 32'h0},
      '{ReqAdd, 8'hff, 20'h00000, 1'b0, 32'h0},
      '{ReqAdd, 8'h80, 20'h12345, 1'b0, 32'h0},
      '{ReqAdd, 8'h01, 20'h54321, 1'b0, 32'h0},
      '{ReqGenerate, 8'hff, 20'd999999, 1'b0, 32'h0},
      // time above range and alternating-bit patterns
      '{ReqGenerate, 8'h00, 20'hfffff, 1'b0, 32'h0},
      '{ReqGenerate, 8'haa, 20'h55555, 1'b0, 32'h0},
      '{ReqGenerate, 8'h55, 20'haaaaa, 1'b0, 32'h0},
      '{ReqAdd, 8'h5a, 20'h0, 1'b0, 32'h0},
      '{ReqAdd, 8'ha5, 20'h0, 1'b0, 32'h0},
      '{ReqGenerate, 8'h00, 20'h00001, 1'b0, 32'h0},
      '{ReqGenerate, 8'h00, 20'h80000, 1'b0, 32'h0}
   };

   initial begin
      int unsigned burst;
      int unsigned seq_len;
      mismatch_count = 0;
      words_seen = 0;
      items_sent = 0;
      generates_sent = 0;
      hold_rsp = 1'b0;
      pos = '0;
      for (int i = 0; i < PoolBytes; i++) pool[i] = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_req_type <= ReqAdd;
      req_entropy_byte <= '0;
      req_time_usec <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) begin
         fixed_flags.push_back(table_rows[i].has_word);
         fixed_words.push_back(table_rows[i].word);
         if (table_rows[i].kind == ReqAdd) begin
            void'(fixed_flags.pop_back());
            void'(fixed_words.pop_back());
         end
         send_item(table_rows[i].kind, table_rows[i].entropy, table_rows[i].usec);
         if (i % 3 == 2) drop_valid();
      end
      // pause until every word has come
      drain();

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1'b1;
      fork
         begin
            repeat (2000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_item(ReqGenerate, 8'($urandom), 20'($urandom));
      join

      while (items_sent < RandomItems + $size(table_rows)) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst; b++) begin
            if ($urandom_range(0, 9) < 8) begin
               // seed run followed by a generate
               seq_len = $urandom_range(0, 12);
               for (int s = 0; s < seq_len; s++)
                  send_item(ReqAdd, 8'($urandom), 20'($urandom));
               send_item(ReqGenerate, 8'($urandom),
                         ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                     : 20'($urandom_range(0, 999999)));
            end else
               send_item(ReqAdd, 8'($urandom), 20'($urandom));
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      drain();
      repeat (400) @(posedge clock);

      $display("covered %0d items, %0d generate items, %0d words checked",
               items_sent, generates_sent, words_seen);
      $display("pool wrapped, time patterns beyond range and long output stalls exercised");
      if (mismatch_count == 0 && words_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (words_due.size() != 0) $error("random_word: %0d items never came", words_due.size());
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mep_pkg.sv
hw/rtl/md5_entropy_pool_rng.sv
hw/rtl/mep_checker.sv
test/md5_entropy_pool_rng_test.sv
